FILE: rtl/amsd_pkg.sv
// Shared constants, types and segment functions for the ADC millivolt display encoder.
package amsd_pkg;

  localparam int ADC_BITS    = 12;
  localparam int MV_W        = 13;
  localparam int CELL_W      = 8;
  localparam int DIGIT_CELLS = 6;
  localparam int DP_CELL     = DIGIT_CELLS - 3;
  localparam int DIGITS      = 4;
  localparam int PROD_W      = ADC_BITS + MV_W + 1;

  localparam logic [MV_W-1:0] FULL_SCALE_RESET = MV_W'(3300);

  localparam logic [CELL_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [CELL_W-1:0] SEG_DP    = 8'h80;

  // LCD bit that receives segment a, b, c, d, e, f, g, dp
  localparam logic [2:0] LCD_BIT [CELL_W] = '{3'd7, 3'd6, 3'd5, 3'd0, 3'd1, 3'd3, 3'd2, 3'd4};

  typedef logic [3:0]        digit_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [MV_W-1:0]   mv_t;

  function automatic cell_t seg_of_digit(digit_t d);
    cell_t s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic cell_t to_lcd(cell_t seg);
    cell_t lcd;
    lcd = '0;
    for (int k = 0; k < CELL_W; k++) begin
      lcd[LCD_BIT[k]] = seg[k];
    end
    return lcd;
  endfunction

endpackage

FILE: rtl/amsd_in_if.sv
// Input channel carrying one raw ADC sample per item.
interface amsd_in_if
  import amsd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

FILE: rtl/amsd_out_if.sv
// Result channel carrying the millivolt value and six LCD cell bytes per item.
interface amsd_out_if
  import amsd_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [12:0] millivolts;
  logic [7:0]  cell0;
  logic [7:0]  cell1;
  logic [7:0]  cell2;
  logic [7:0]  cell3;
  logic [7:0]  cell4;
  logic [7:0]  cell5;

  modport source (output valid, output millivolts, output cell0, output cell1, output cell2,
                  output cell3, output cell4, output cell5, input ready);
  modport sink   (input valid, input millivolts, input cell0, input cell1, input cell2,
                  input cell3, input cell4, input cell5, output ready);
endinterface

FILE: rtl/adc_millivolt_segment_display_top.sv
// ADC sample to millivolt seven-segment LCD encoder, top level.
//
// Usage:
//   in_ch   valid/ready channel, one 12-bit ADC sample per item.
//   out_ch  valid/ready channel, one item per sample: millivolts and six LCD
//           bytes, left to right, leading cells blank, decimal point on cell 3.
//   cfg_we / cfg_wdata write the full-scale reference in millivolts; write
//           only while no item is in flight.
// Between input accept and output valid, the first register holds the scaled
// millivolt value (one 12x13 multiply), the second the LCD bytes (constant
// reciprocal multiplies for the decimal digits).
// Throughput is one item per cycle while the receiver keeps up; in_ch.ready
// stays high while the output register drains or is empty.
// If the receiver stalls, the result holds in the output register and the
// middle stage, if empty, still takes one more item before in_ch.ready drops.
// Reset empties both stages and sets the reference to 3300 mV.
module adc_millivolt_segment_display_top
  import amsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  amsd_in_if.sink           in_ch,
  amsd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [MV_W-1:0]   cfg_wdata
);

  mv_t   full_scale_r;
  logic  mid_valid_r;
  logic  out_valid_r;
  mv_t   mv_r;
  mv_t   out_mv_r;
  cell_t cells_r [DIGIT_CELLS];

  logic               out_load;
  logic               mid_load;
  logic [PROD_W-1:0]  prod;
  mv_t                mv_nxt;

  logic [28:0]        q10_prod;
  logic [25:0]        q100_prod;
  logic [26:0]        q1000_prod;
  logic [9:0]         q10;
  logic [6:0]         q100;
  logic [3:0]         q1000;
  mv_t                d0_full;
  logic [9:0]         d1_full;
  logic [6:0]         d2_full;
  digit_t             digit [DIGITS];
  logic               blank [DIGITS];
  cell_t              cells_nxt [DIGIT_CELLS];

  assign out_load    = !out_valid_r || out_ch.ready;
  assign mid_load    = !mid_valid_r || out_load;
  assign in_ch.ready = mid_load;

  assign prod   = PROD_W'(in_ch.adc_sample) * PROD_W'(full_scale_r)
                + PROD_W'(1 << (ADC_BITS - 1));
  assign mv_nxt = prod[ADC_BITS +: MV_W];

  assign q10_prod   = 29'(mv_r) * 29'(52429);
  assign q100_prod  = 26'(mv_r) * 26'(5243);
  assign q1000_prod = 27'(mv_r) * 27'(8389);
  assign q10   = q10_prod[19 +: 10];
  assign q100  = q100_prod[19 +: 7];
  assign q1000 = q1000_prod[23 +: 4];

  assign d0_full = mv_r - ({q10, 3'b000} + {2'b00, q10, 1'b0});
  assign d1_full = q10 - (10'({q100, 3'b000}) + 10'({q100, 1'b0}));
  assign d2_full = q100 - (7'({q1000, 3'b000}) + 7'({q1000, 1'b0}));

  assign digit[0] = d0_full[3:0];
  assign digit[1] = d1_full[3:0];
  assign digit[2] = d2_full[3:0];
  assign digit[3] = q1000;

  assign blank[0] = (mv_r == '0);
  assign blank[1] = (q10 == '0);
  assign blank[2] = (q100 == '0);
  assign blank[3] = (q1000 == '0);

  always_comb begin
    cell_t seg [DIGIT_CELLS];
    for (int c = 0; c < DIGIT_CELLS; c++) begin
      seg[c] = SEG_BLANK;
    end
    for (int i = 0; i < DIGITS; i++) begin
      seg[DIGIT_CELLS-1-i] = blank[i] ? SEG_BLANK : seg_of_digit(digit[i]);
    end
    seg[DP_CELL] = seg[DP_CELL] | SEG_DP;
    for (int c = 0; c < DIGIT_CELLS; c++) begin
      cells_nxt[c] = to_lcd(seg[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= FULL_SCALE_RESET;
      mid_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        full_scale_r <= cfg_wdata;
      end
      if (mid_load) begin
        mid_valid_r <= in_ch.valid;
      end
      if (out_load) begin
        out_valid_r <= mid_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_load && in_ch.valid) begin
      mv_r <= mv_nxt;
    end
    if (out_load && mid_valid_r) begin
      out_mv_r <= mv_r;
      cells_r  <= cells_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.millivolts = out_mv_r;
  assign out_ch.cell0      = cells_r[0];
  assign out_ch.cell1      = cells_r[1];
  assign out_ch.cell2      = cells_r[2];
  assign out_ch.cell3      = cells_r[3];
  assign out_ch.cell4      = cells_r[4];
  assign out_ch.cell5      = cells_r[5];

endmodule

FILE: rtl/amsd_checker.sv
// Port-level checker for the display encoder and its bind to the top level.
module amsd_checker
  import amsd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MV_W-1:0]   millivolts,
  input logic [CELL_W-1:0] cell0,
  input logic [CELL_W-1:0] cell1,
  input logic [CELL_W-1:0] cell3,
  input logic [CELL_W-1:0] cell5
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

  a_zero_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((millivolts == '0) == (cell5 == '0)))
    else $error("ones cell blanking does not match the millivolt value");

  a_fixed_cells: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cell0 == '0) && (cell1 == '0) && cell3[4])
    else $error("leading cells or decimal point wrong");

endmodule

bind adc_millivolt_segment_display_top amsd_checker u_amsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .millivolts (out_ch.millivolts),
  .cell0      (out_ch.cell0),
  .cell1      (out_ch.cell1),
  .cell3      (out_ch.cell3),
  .cell5      (out_ch.cell5)
);

FILE: tb/sv/tb_adc_millivolt_segment_display_top.sv
`timescale 1ns / 1ps
// Self-checking testbench: ADC samples in, millivolt value and LCD digit bytes checked per item.
module tb_adc_millivolt_segment_display_top
  import amsd_pkg::*;
;

  localparam real         CLK_PERIOD     = 12.0;
  localparam int unsigned TIMEOUT_CYCLES = 100_000;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned STEADY_PHASE   = 3;
  localparam int unsigned PRESSURE_PHASE = 5;
  localparam int unsigned HOLD_CYCLES    = 48;
  localparam int unsigned IDLE_PERCENT   = 34;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam int unsigned PIPE_CYCLES    = 2;
  localparam int unsigned MAX_REPORTS    = 40;

  typedef logic [ADC_BITS-1:0] sample_t;

  typedef struct packed {
    mv_t                          millivolts;
    cell_t [0:DIGIT_CELLS-1]      cells;
  } lcd_frame_t;

  typedef enum logic {ROW_SAMPLE, ROW_FULL_SCALE} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    mv_t        value;
    logic       typed;
    lcd_frame_t frame;
  } directed_row_t;

  localparam cell_t DIGIT_GLYPH [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                         8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  localparam lcd_frame_t ZERO_FRAME = {13'd0, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00};

  localparam int DIRECTED_ROWS = 25;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE,     13'd0,    1'b1, ZERO_FRAME},
    '{ROW_SAMPLE,     13'd4095, 1'b1, {13'd3299, 8'h00, 8'h00, 8'hE5, 8'hD7, 8'hED, 8'hED}},
    '{ROW_SAMPLE,     13'd1,    1'b0, '0},
    '{ROW_SAMPLE,     13'd2048, 1'b0, '0},
    '{ROW_SAMPLE,     13'd124,  1'b0, '0},
    '{ROW_FULL_SCALE, 13'd0,    1'b0, '0},
    '{ROW_SAMPLE,     13'd4095, 1'b1, ZERO_FRAME},
    '{ROW_SAMPLE,     13'd2730, 1'b0, '0},
    '{ROW_FULL_SCALE, 13'd5000, 1'b0, '0},
    '{ROW_SAMPLE,     13'd4095, 1'b1, {13'd4999, 8'h00, 8'h00, 8'h6C, 8'hFD, 8'hED, 8'hED}},
    '{ROW_SAMPLE,     13'd0,    1'b1, ZERO_FRAME},
    '{ROW_SAMPLE,     13'd820,  1'b0, '0},
    '{ROW_FULL_SCALE, 13'd8191, 1'b0, '0},
    '{ROW_SAMPLE,     13'd4095, 1'b1, {13'd8189, 8'h00, 8'h00, 8'hEF, 8'h70, 8'hEF, 8'hED}},
    '{ROW_SAMPLE,     13'd1,    1'b1, {13'd2, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'hC7}},
    '{ROW_SAMPLE,     13'd2048, 1'b0, '0},
    '{ROW_FULL_SCALE, 13'd2048, 1'b0, '0},
    '{ROW_SAMPLE,     13'd1,    1'b1, {13'd1, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h60}},
    '{ROW_SAMPLE,     13'd3,    1'b0, '0},
    '{ROW_FULL_SCALE, 13'd2047, 1'b0, '0},
    '{ROW_SAMPLE,     13'd1,    1'b1, ZERO_FRAME},
    '{ROW_FULL_SCALE, 13'd4096, 1'b0, '0},
    '{ROW_SAMPLE,     13'd1000, 1'b1, {13'd1000, 8'h00, 8'h00, 8'h60, 8'hFB, 8'hEB, 8'hEB}},
    '{ROW_SAMPLE,     13'd4095, 1'b0, '0},
    '{ROW_SAMPLE,     13'd2730, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  mv_t  cfg_wdata;

  amsd_in_if  in_ch ();
  amsd_out_if out_ch ();

  adc_millivolt_segment_display_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lcd_frame_t  pending_frames [$];
  mv_t         full_scale_mv;
  logic        steady;
  logic        hold_request;
  int unsigned mismatch_count;
  int unsigned samples_accepted;
  int unsigned frames_checked;
  int unsigned scale_writes;

  function automatic lcd_frame_t scale_and_encode(input sample_t sample, input mv_t full_scale);
    lcd_frame_t       frame;
    logic [PROD_W-1:0] scaled;
    int unsigned      rest;
    cell_t            glyph;
    scaled = PROD_W'(sample) * PROD_W'(full_scale) + PROD_W'(1 << (ADC_BITS - 1));
    frame.millivolts = mv_t'(scaled >> ADC_BITS);
    rest = int'(scaled >> ADC_BITS);
    for (int c = DIGIT_CELLS - 1; c >= 0; c--) begin
      glyph = '0;
      if (rest != 0) begin
        glyph = DIGIT_GLYPH[rest % 10];
        rest  = rest / 10;
      end
      if (c == DP_CELL) begin
        glyph[7] = 1'b1;
      end
      // a b c dp f g e d onto LCD bits 7..0
      frame.cells[c] = {glyph[0], glyph[1], glyph[2], glyph[7],
                        glyph[5], glyph[6], glyph[4], glyph[3]};
    end
    return frame;
  endfunction

  function automatic sample_t pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) begin
      return '0;
    end else if (roll < 10) begin
      return '1;
    end else if (roll < 20) begin
      return sample_t'($urandom_range(31));
    end
    return sample_t'($urandom_range(4095));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic offer_sample(input sample_t sample, input logic typed, input lcd_frame_t frame);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid      <= 1'b0;
      in_ch.adc_sample <= sample_t'($urandom);
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= sample;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    samples_accepted++;
    pending_frames.push_back(typed ? frame : scale_and_encode(sample, full_scale_mv));
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_frames.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (PIPE_CYCLES + 2) @(posedge clk);
  endtask

  task automatic write_full_scale(input mv_t value);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    full_scale_mv = value;
    scale_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever begin
      #(CLK_PERIOD / 2.0) clk = ~clk;
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_adc_millivolt_segment_display_top: done, errors");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin : check_frames
    lcd_frame_t want;
    lcd_frame_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.millivolts, out_ch.cell0, out_ch.cell1, out_ch.cell2,
              out_ch.cell3, out_ch.cell4, out_ch.cell5};
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected item, millivolts %0d", seen.millivolts));
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (seen.millivolts !== want.millivolts) begin
          report_mismatch($sformatf("millivolts: got %0d, want %0d",
                                    seen.millivolts, want.millivolts));
        end
        for (int c = 0; c < DIGIT_CELLS; c++) begin
          if (seen.cells[c] !== want.cells[c]) begin
            report_mismatch($sformatf("cell%0d: got %02h, want %02h (millivolts %0d)",
                                      c, seen.cells[c], want.cells[c], want.millivolts));
          end
        end
      end
    end
  end

  initial begin
    mv_t scale_plan [PHASES];
    scale_plan       = '{13'd3300, 13'd8191, 13'd0, 13'd5000, 13'd1, 13'd4095, 13'd0, 13'd0};
    scale_plan[6]    = mv_t'($urandom_range(5000));
    scale_plan[7]    = mv_t'($urandom_range(8191));
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.adc_sample = '0;
    full_scale_mv    = FULL_SCALE_RESET;
    steady           = 1'b0;
    hold_request     = 1'b0;
    mismatch_count   = 0;
    samples_accepted = 0;
    frames_checked   = 0;
    scale_writes     = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_FULL_SCALE) begin
        write_full_scale(DIRECTED[r].value);
      end else begin
        offer_sample(sample_t'(DIRECTED[r].value), DIRECTED[r].typed, DIRECTED[r].frame);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_full_scale(scale_plan[p]);
      steady = (p == STEADY_PHASE);
      if (p == PRESSURE_PHASE) begin
        hold_request = 1'b1;
      end
      repeat (RANDOM_ITEMS / PHASES) offer_sample(pick_sample(), 1'b0, '0);
    end
    steady = 1'b0;
    settle();

    if (pending_frames.size() != 0) begin
      report_mismatch($sformatf("%0d items never came out", pending_frames.size()));
    end

    $display("run: %0d samples in, %0d LCD frames checked, %0d full-scale writes",
             samples_accepted, frames_checked, scale_writes);
    $display("run: reset scale, zero and out-of-range scales, half-way rounding, back-pressure");
    if (mismatch_count == 0) begin
      $display("tb_adc_millivolt_segment_display_top: done, clean");
    end else begin
      $display("tb_adc_millivolt_segment_display_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/amsd_pkg.sv
rtl/amsd_in_if.sv
rtl/amsd_out_if.sv
rtl/adc_millivolt_segment_display_top.sv
rtl/amsd_checker.sv
tb/sv/tb_adc_millivolt_segment_display_top.sv
